[hw/rtl/tmprof_pkg.sv]
// shared types, constants and interface structs of the trapezoidal motion profile
`default_nettype none

package tmprof_pkg;

	// field widths
	localparam int POS_W    = 32;
	localparam int VEL_W    = 32;
	localparam int LIMIT_W  = 31;
	localparam int DT_W     = 24;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	// square root: one result bit per step
	localparam int SQRT_STEPS = 32;
	localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

	// snap window, raw Q16.16 (0.01)
	localparam logic [31:0] SNAP_LIMIT = 32'd655;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_MAX_VELOCITY = 1'b0,
		REG_MAX_ACCEL    = 1'b1
	} cfg_reg_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MUL_SAFE = 2'd0,
		MUL_DMAX = 2'd1,
		MUL_INC  = 2'd2
	} mul_sel_t;

	// input beat
	typedef struct packed {
		logic                    mode;
		logic signed [POS_W-1:0] target_position;
		logic signed [POS_W-1:0] start_position;
		logic [DT_W-1:0]         tick_duration;
	} in_beat_t;

	// output beat
	typedef struct packed {
		logic signed [POS_W-1:0] setpoint_position;
		logic signed [VEL_W-1:0] setpoint_velocity;
	} out_beat_t;

	// controller to datapath
	typedef struct packed {
		logic     capture;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     sqrt_load;
		logic     sqrt_step;
		logic     slew;
		logic     update;
		logic     out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_reset;
		logic dt_zero;
	} status_t;

endpackage

`default_nettype wire

[hw/rtl/tmprof_ctrl.sv]
// sequencing state machine of the trapezoidal motion profile
`default_nettype none

module tmprof_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	input  wire tmprof_pkg::status_t status,
	output tmprof_pkg::cmd_t        cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_MSAFE  = 9'b000000010,
		ST_SQLOAD = 9'b000000100,
		ST_SQRT   = 9'b000001000,
		ST_MDMAX  = 9'b000010000,
		ST_SLEW   = 9'b000100000,
		ST_MINC   = 9'b001000000,
		ST_UPDATE = 9'b010000000,
		ST_EMIT   = 9'b100000000
	} state_t;

	state_t                            state_q, state_d;
	logic [tmprof_pkg::SQRT_CNT_W-1:0] cnt_q;
	logic                              out_valid_q;
	logic                              accept;
	logic                              slot_free;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// next state and commands
	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		cmd.mul_sel   = tmprof_pkg::MUL_SAFE;
		cmd.capture   = accept;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (status.is_reset || status.dt_zero) begin
						state_d = ST_EMIT;
					end else begin
						state_d = ST_MSAFE;
					end
				end
			end
			ST_MSAFE: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tmprof_pkg::MUL_SAFE;
				state_d     = ST_SQLOAD;
			end
			ST_SQLOAD: begin
				cmd.sqrt_load = 1'b1;
				state_d       = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_step = 1'b1;
				if (cnt_q == '0) begin
					state_d = ST_MDMAX;
				end
			end
			ST_MDMAX: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tmprof_pkg::MUL_DMAX;
				state_d     = ST_SLEW;
			end
			ST_SLEW: begin
				cmd.slew = 1'b1;
				state_d  = ST_MINC;
			end
			ST_MINC: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = tmprof_pkg::MUL_INC;
				state_d     = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state, step counter and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_SQLOAD) begin
				cnt_q <= tmprof_pkg::SQRT_CNT_W'(tmprof_pkg::SQRT_STEPS - 1);
			end else if (state_q == ST_SQRT) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// a waiting result beat is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || out_ready))
		else $error("result beat overwritten");

	// the root runs its full count before leaving
	a_sqrt_len: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT && cnt_q != '0) |=> (state_q == ST_SQRT))
		else $error("square root cut short");

	// a plain tick beat starts the arithmetic sequence
	a_tick_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !status.is_reset && !status.dt_zero) |=> (state_q == ST_MSAFE))
		else $error("tick beat did not start the sequence");

	// no new beat is taken while a step is in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SQRT) |-> !in_ready)
		else $error("input taken during computation");

endmodule

`default_nettype wire

[hw/rtl/tmprof_dpath.sv]
// datapath: state, limits, shared multiplier, square root and update logic
`default_nettype none

module tmprof_dpath (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire tmprof_pkg::in_beat_t                in_data,
	input  wire logic                                cfg_valid,
	input  wire logic [tmprof_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [tmprof_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire tmprof_pkg::cmd_t                    cmd,
	output tmprof_pkg::status_t                      status,
	output tmprof_pkg::out_beat_t                    out_data
);

	// state and limits
	logic signed [31:0] pos_q, vel_q;
	logic [30:0]        vmax_q, amax_q;

	// item context
	logic signed [31:0] target_q;
	logic [23:0]        dt_q;
	logic [31:0]        adist_q;
	logic               dist_neg_q;

	// multiplier and root
	logic [63:0] prod_q;
	logic [63:0] x_q;
	logic [33:0] rem_q;
	logic [31:0] res_q;

	tmprof_pkg::out_beat_t out_q;

	// saturate a 34-bit signed sum to 32 bits
	function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
		logic signed [31:0] r;
		if (v > 34'sh0_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (v < -34'sh0_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// distance to target at 33 bits
	logic signed [32:0] dist_full;
	logic [32:0]        dist_mag;
	always_comb begin
		dist_full = 33'(signed'(in_data.target_position)) - 33'(signed'(pos_q));
		dist_mag  = dist_full[32] ? 33'(-dist_full) : 33'(dist_full);
	end

	assign status.is_reset = in_data.mode;
	assign status.dt_zero  = (in_data.tick_duration == '0);

	// speed magnitude
	logic [32:0] vel_neg;
	logic [31:0] vel_mag;
	always_comb begin
		vel_neg = -{vel_q[31], vel_q};
		vel_mag = vel_q[31] ? vel_neg[31:0] : vel_q;
	end

	// shared multiplier operands
	logic [31:0] op_a, op_b;
	always_comb begin
		case (cmd.mul_sel)
			tmprof_pkg::MUL_SAFE: begin
				op_a = {1'b0, amax_q};
				op_b = adist_q;
			end
			tmprof_pkg::MUL_DMAX: begin
				op_a = {1'b0, amax_q};
				op_b = {8'd0, dt_q};
			end
			tmprof_pkg::MUL_INC: begin
				op_a = vel_mag;
				op_b = {8'd0, dt_q};
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// one root bit per step
	logic [35:0] sq_sh, sq_trial, sq_diff;
	always_comb begin
		sq_sh    = {rem_q, x_q[63:62]};
		sq_trial = {2'b00, res_q, 2'b01};
		sq_diff  = sq_sh - sq_trial;
	end

	// velocity slew toward the ideal speed
	logic [30:0]        ideal_mag, dmax;
	logic signed [33:0] ideal_s, vel_s, err_s;
	logic [33:0]        err_mag;
	logic signed [31:0] vel_slew;
	always_comb begin
		ideal_mag = (res_q < {1'b0, vmax_q}) ? res_q[30:0] : vmax_q;
		ideal_s   = dist_neg_q ? -$signed({3'b000, ideal_mag}) : $signed({3'b000, ideal_mag});
		vel_s     = 34'(vel_q);
		err_s     = ideal_s - vel_s;
		err_mag   = err_s[33] ? 34'(-err_s) : 34'(err_s);
		dmax      = prod_q[54:24];
		if (err_mag <= {3'b000, dmax}) begin
			vel_slew = ideal_s[31:0];
		end else if (!err_s[33]) begin
			vel_slew = sat32(vel_s + $signed({3'b000, dmax}));
		end else begin
			vel_slew = sat32(vel_s - $signed({3'b000, dmax}));
		end
	end

	// position integration with rounding, and the snap window
	logic [56:0]        rnd;
	logic [32:0]        inc;
	logic signed [33:0] sinc, pos_sum;
	logic               snap;
	always_comb begin
		rnd     = prod_q[56:0] + 57'(1 << 23);
		inc     = rnd[56:24];
		sinc    = vel_q[31] ? -$signed({1'b0, inc}) : $signed({1'b0, inc});
		pos_sum = 34'(pos_q) + sinc;
		snap    = (adist_q <= tmprof_pkg::SNAP_LIMIT) && (vel_mag <= tmprof_pkg::SNAP_LIMIT);
	end

	// state and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			vel_q  <= '0;
			vmax_q <= '0;
			amax_q <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					tmprof_pkg::REG_MAX_VELOCITY: vmax_q <= cfg_data[30:0];
					tmprof_pkg::REG_MAX_ACCEL:    amax_q <= cfg_data[30:0];
					default: begin
					end
				endcase
			end
			if (cmd.capture && in_data.mode) begin
				pos_q <= in_data.start_position;
				vel_q <= '0;
			end else if (cmd.slew) begin
				vel_q <= vel_slew;
			end else if (cmd.update) begin
				if (snap) begin
					pos_q <= target_q;
					vel_q <= '0;
				end else begin
					pos_q <= sat32(pos_sum);
				end
			end
		end
	end

	// item context, products, root and output register
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			target_q   <= in_data.target_position;
			dt_q       <= in_data.tick_duration;
			adist_q    <= dist_mag[31:0];
			dist_neg_q <= dist_full[32];
		end
		if (cmd.mul_en) begin
			prod_q <= 64'(op_a) * 64'(op_b);
		end
		if (cmd.sqrt_load) begin
			x_q   <= {prod_q[62:0], 1'b0};
			rem_q <= '0;
			res_q <= '0;
		end else if (cmd.sqrt_step) begin
			x_q <= {x_q[61:0], 2'b00};
			if (sq_sh >= sq_trial) begin
				rem_q <= sq_diff[33:0];
				res_q <= {res_q[30:0], 1'b1};
			end else begin
				rem_q <= sq_sh[33:0];
				res_q <= {res_q[30:0], 1'b0};
			end
		end
		if (cmd.out_load) begin
			out_q.setpoint_position <= pos_q;
			out_q.setpoint_velocity <= vel_q;
		end
	end

	assign out_data = out_q;

endmodule

`default_nettype wire

[hw/rtl/trapezoidal_motion_profile.sv]
// Single-axis trapezoidal setpoint generator, signed Q16.16 position and velocity.
// A tick beat passes from acceptance to the next input ready through a capture,
// three multiplies on one shared 32x32 multiplier, and the square root of
// 2*a*|distance|, which produces one result bit per cycle. A reset beat or
// a tick with zero duration goes from acceptance straight to the emit state, which
// loads the output register. A finished result sits in an output register, so the
// next beat is taken while the previous result still waits to be read.
// Configuration writes are accepted in any cycle and are meant for idle periods.
`default_nettype none

module trapezoidal_motion_profile (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire tmprof_pkg::in_beat_t              in_data,
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output tmprof_pkg::out_beat_t                  out_data,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [tmprof_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tmprof_pkg::CFG_DATA_W-1:0] cfg_data
);

	tmprof_pkg::cmd_t    cmd;
	tmprof_pkg::status_t status;

	// register writes always taken
	assign cfg_ready = 1'b1;

	// sequencing
	tmprof_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// arithmetic and state
	tmprof_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule

`default_nettype wire
